/* src/pdps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise dot product sum package
// Shared constants, payload structs and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pdps_pkg;

  // Capacity of the block.
  localparam int MAX_DIM    = 64;
  localparam int MAX_POINTS = 4096;

  // Derived widths.
  localparam int DIM_AW  = $clog2(MAX_DIM);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int WIDTH_W = 7;
  localparam int SUM_W   = 28;
  localparam int SQT_W   = 49;
  localparam int COST_W  = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_OFFSET = 1'd1;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_PARTIAL  = 2'd2;

  // One input request.
  typedef struct packed {
    logic signed [15:0] feature;
    logic               last;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic signed [COST_W-1:0] cost;
    logic [CNT_W-1:0]         point_count;
    logic [1:0]               status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic update;
    logic pass_start;
    logic pass_step;
    logic term_sub;
    logic term_mul;
    logic finish;
  } pdps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic bad;
    logic pass_done;
    logic pipe_empty;
    logic out_free;
  } pdps_sts_t;

endpackage

/* src/pdps_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pdps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/pdps_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise dot product sum controller
// Sequences element accumulation, the column sum pass and the final terms.
// ----------------------------------------------------------------------------
module pdps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pdps_pkg::pdps_sts_t sts_i,
  output pdps_pkg::pdps_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_PASS,
    S_SUB,
    S_MUL,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    stall_d = stall_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !stall_q) begin
          cmd_o.accept = 1'b1;
          state_d      = S_UPD;
          stall_d      = 1'b1;
        end
      end
      S_UPD: begin
        cmd_o.update     = 1'b1;
        cmd_o.pass_start = 1'b1;
        if (!sts_i.last) begin
          state_d = S_IDLE;
          stall_d = 1'b0;
        end else if (sts_i.bad) begin
          state_d = S_FIN;
        end else begin
          state_d = S_PASS;
        end
      end
      S_PASS: begin
        cmd_o.pass_step = !sts_i.pass_done;
        if (sts_i.pass_done && sts_i.pipe_empty) begin
          state_d = S_SUB;
        end
      end
      S_SUB: begin
        cmd_o.term_sub = 1'b1;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.term_mul = 1'b1;
        state_d        = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
          stall_d      = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
        stall_d = 1'b0;
      end
    endcase
  end

  // State and the registered stall output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  assign in_stall_o = stall_q;

endmodule

/* src/pdps_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise dot product sum datapath
// Column sum memory, running totals, the squaring pass and the result register.
// ----------------------------------------------------------------------------
module pdps_datapath (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  pdps_pkg::pdps_cmd_t                        cmd_i,
  output pdps_pkg::pdps_sts_t                        sts_o,
  input  logic                                       cfg_we_i,
  input  logic [pdps_pkg::CFG_IDX_W-1:0]             cfg_idx_i,
  input  logic [pdps_pkg::CFG_DATA_W-1:0]            cfg_data_i,
  input  pdps_pkg::in_item_t                         in_item_i,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output pdps_pkg::out_item_t                        out_item_o
);

  localparam int AW  = pdps_pkg::DIM_AW;
  localparam int WW  = pdps_pkg::WIDTH_W;
  localparam int CW  = pdps_pkg::CNT_W;
  localparam int SW  = pdps_pkg::SUM_W;
  localparam int QW  = pdps_pkg::SQT_W;
  localparam int OW  = pdps_pkg::COST_W;
  localparam int PNW = 2 * CW;

  // Configuration registers.
  logic [WW-1:0] row_width_q;
  logic          use_offset_q;

  // Accumulation state.
  logic [pdps_pkg::MAX_DIM-1:0] col_valid_q;
  logic [QW-1:0]                sqt_q;
  logic [CW-1:0]                row_cnt_q;
  logic [AW-1:0]                col_idx_q;
  logic signed [15:0]           offset_q;
  logic                         overflow_q;

  // Element in flight.
  logic signed [15:0] feat_q;
  logic               last_q;
  logic [AW-1:0]      widx_q;
  logic               acc_en_q;
  logic [31:0]        fsq_q;
  logic               vb_q;

  // Pass and final term registers.
  logic [WW-1:0]        pidx_q;
  logic                 p1_q, p2_q;
  logic signed [55:0]   sqr_q;
  logic [OW-1:0]        acc_q;
  logic [31:0]          o2_q;
  logic [PNW-1:0]       pn_q;
  logic [56:0]          prod_q;

  // Result register.
  logic                 out_valid_q;
  pdps_pkg::out_item_t  out_q;

  // Effective width and counted columns.
  logic [WW-1:0] eff_w, counted, idx_ext;
  logic          row_end, ovf_now;

  always_comb begin
    if (row_width_q == '0) begin
      eff_w = WW'(1);
    end else if (row_width_q > WW'(pdps_pkg::MAX_DIM)) begin
      eff_w = WW'(pdps_pkg::MAX_DIM);
    end else begin
      eff_w = row_width_q;
    end
    counted = use_offset_q ? eff_w - WW'(1) : eff_w;
  end

  assign idx_ext = WW'(col_idx_q);
  assign row_end = (idx_ext + WW'(1)) >= eff_w;
  assign ovf_now = row_cnt_q >= CW'(pdps_pkg::MAX_POINTS);

  // Column sum memory access.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [SW-1:0] ram_wdata, ram_rdata, rd_sum;

  assign ram_re    = cmd_i.accept || cmd_i.pass_step;
  assign ram_raddr = cmd_i.pass_step ? pidx_q[AW-1:0] : col_idx_q;
  assign rd_sum    = vb_q ? ram_rdata : '0;
  assign ram_we    = cmd_i.update && acc_en_q;
  assign ram_wdata = rd_sum + SW'(feat_q);

  pdps_ram #(
    .WIDTH (SW),
    .DEPTH (pdps_pkg::MAX_DIM)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Products feeding the registers.
  logic signed [31:0] fsq_d, o2_d;
  logic signed [55:0] sqr_d;
  logic [PNW-1:0]     pn_d;
  logic [PNW-2:0]     pairs;
  logic [56:0]        prod_d;
  logic [OW-1:0]      diff, cost_d;
  logic [1:0]         status_d;

  always_comb begin
    fsq_d  = 32'(in_item_i.feature) * 32'(in_item_i.feature);
    sqr_d  = 56'($signed(rd_sum)) * 56'($signed(rd_sum));
    o2_d   = 32'(offset_q) * 32'(offset_q);
    if (row_cnt_q == '0) begin
      pn_d = '0;
    end else begin
      pn_d = PNW'(row_cnt_q) * PNW'(row_cnt_q - CW'(1));
    end
    pairs  = pn_q[PNW-1:1];
    prod_d = 57'(o2_q) * 57'(pairs);
    diff   = acc_q - OW'(sqt_q);
    if (overflow_q) begin
      status_d = pdps_pkg::ST_OVERFLOW;
    end else if (col_idx_q != '0) begin
      status_d = pdps_pkg::ST_PARTIAL;
    end else begin
      status_d = pdps_pkg::ST_OK;
    end
    if (status_d != pdps_pkg::ST_OK) begin
      cost_d = '0;
    end else if (use_offset_q) begin
      cost_d = acc_q - OW'(prod_q);
    end else begin
      cost_d = acc_q;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q  <= WW'(1);
      use_offset_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pdps_pkg::REG_ROW_WIDTH:  row_width_q  <= cfg_data_i[WW-1:0];
        pdps_pkg::REG_USE_OFFSET: use_offset_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Running state: element bookkeeping, totals and clearing after a result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_valid_q <= '0;
      sqt_q       <= '0;
      row_cnt_q   <= '0;
      col_idx_q   <= '0;
      offset_q    <= '0;
      overflow_q  <= 1'b0;
    end else if (cmd_i.finish) begin
      col_valid_q <= '0;
      sqt_q       <= '0;
      row_cnt_q   <= '0;
      col_idx_q   <= '0;
      offset_q    <= '0;
      overflow_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        if (ovf_now) begin
          overflow_q <= 1'b1;
        end else if (row_cnt_q == '0 && idx_ext == eff_w - WW'(1)) begin
          offset_q <= in_item_i.feature;
        end
        if (row_end) begin
          col_idx_q <= '0;
          if (!ovf_now) begin
            row_cnt_q <= row_cnt_q + CW'(1);
          end
        end else begin
          col_idx_q <= col_idx_q + AW'(1);
        end
      end
      if (ram_we) begin
        col_valid_q[widx_q] <= 1'b1;
        sqt_q               <= sqt_q + QW'(fsq_q);
      end
    end
  end

  // Element registers and the valid bit of the entry being read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      feat_q   <= in_item_i.feature;
      last_q   <= in_item_i.last;
      widx_q   <= col_idx_q;
      acc_en_q <= !ovf_now && (idx_ext < counted);
      fsq_q    <= unsigned'(fsq_d);
    end
    if (ram_re) begin
      vb_q <= col_valid_q[ram_raddr];
    end
  end

  // Pass pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= 1'b0;
      p2_q <= 1'b0;
    end else begin
      p1_q <= cmd_i.pass_step;
      p2_q <= p1_q;
    end
  end

  // Pass datapath: square each column sum and accumulate, then final terms.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pass_start) begin
      pidx_q <= '0;
    end else if (cmd_i.pass_step) begin
      pidx_q <= pidx_q + WW'(1);
    end
    if (p1_q) begin
      sqr_q <= sqr_d;
    end
    if (cmd_i.pass_start) begin
      acc_q <= '0;
    end else if (p2_q) begin
      acc_q <= acc_q + OW'(unsigned'(sqr_q));
    end else if (cmd_i.term_sub) begin
      // Exact halving of an even value.
      acc_q <= {diff[OW-1], diff[OW-1:1]};
    end
    if (cmd_i.term_sub) begin
      o2_q <= unsigned'(o2_d);
      pn_q <= pn_d;
    end
    if (cmd_i.term_mul) begin
      prod_q <= prod_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.cost        <= cost_d;
      out_q.point_count <= row_cnt_q;
      out_q.status      <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Status towards the controller.
  always_comb begin
    sts_o            = '0;
    sts_o.last       = last_q;
    sts_o.bad        = overflow_q || (col_idx_q != '0);
    sts_o.pass_done  = pidx_q == counted;
    sts_o.pipe_empty = !p1_q && !p2_q;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

/* src/pairwise_dot_product_sum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pairwise dot product sum
// Accumulates streamed feature vectors and reports the sum of all pairwise
// dot products, less the offset term when enabled, on the element marked last.
// ----------------------------------------------------------------------------
// The block cannot take a new element until the last one is written back, as
// the column sum memory is read on acceptance and written in the following cycle.
// After the last element, a pass squares and accumulates the column sums and the
// final terms follow; a bad status skips the pass and goes straight to the result.
// A waiting result holds back only the finishing step of the next data set.
// Reset is asynchronous and active low; column sums read as zero via valid flags.
module pairwise_dot_product_sum (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pdps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pdps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pdps_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pdps_pkg::out_item_t             out_item_o
);

  pdps_pkg::pdps_cmd_t cmd;
  pdps_pkg::pdps_sts_t sts;

  // Sequencer.
  pdps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  pdps_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
